>>> sv/lsd_pkg.sv
// Shared types, codes and a helper function for the LED strip driver.
`timescale 1ns / 1ps

package lsd_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_SET   = 2'd0;
	localparam logic [1:0] KIND_FILL  = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_BUSY  = 2'd1;
	localparam logic [1:0] STS_RANGE = 2'd2;

	// Wire byte orders.
	localparam logic [2:0] ORD_RGB = 3'd0;
	localparam logic [2:0] ORD_BRG = 3'd1;
	localparam logic [2:0] ORD_RBG = 3'd2;
	localparam logic [2:0] ORD_GBR = 3'd3;
	localparam logic [2:0] ORD_BGR = 3'd4;
	localparam logic [2:0] ORD_GRB = 3'd5;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_COLOR_ORDER = 2'd0;
	localparam logic [1:0] REG_BRIGHTNESS  = 2'd1;
	localparam logic [1:0] REG_PIXEL_COUNT = 2'd2;

	localparam int ADDR_W    = 4;
	localparam int CNT_W     = 11;
	localparam int WORD_BITS = 24;

	// Reset values of the registers.
	localparam logic [2:0]       RST_COLOR_ORDER = ORD_GRB;
	localparam logic [7:0]       RST_BRIGHTNESS  = 8'd255;
	localparam logic [CNT_W-1:0] RST_PIXEL_COUNT = 11'd1024;

	typedef struct packed {
		logic [1:0] kind;
		logic [9:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} lsd_item_t;

	typedef struct packed {
		logic       line_level;
		logic       busy_res;
		logic [1:0] status;
	} lsd_res_t;

	typedef struct packed {
		logic [2:0]       color_order;
		logic [7:0]       brightness;
		logic [CNT_W-1:0] pixel_count;
	} lsd_cfg_t;

	typedef enum logic [1:0] {
		WR_SET,
		WR_FILL,
		WR_CLR
	} lsd_wr_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        wr_en;
		lsd_wr_sel_t wr_sel;
		logic        fill_load;
		logic        sweep_clr;
		logic        sweep_inc;
		logic        rd_en;
		logic        shift_load;
		logic        tick_send;
		logic        frame_start;
		logic        gap_clr;
		logic        gap_inc;
		logic        push;
		lsd_res_t    res;
	} lsd_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic level;
		logic bit_last;
		logic word_last;
		logic pixel_last;
		logic gap_last;
		logic clr_last;
		logic fill_last;
		logic cnt_zero;
		logic idx_oor;
		logic q_full;
	} lsd_sts_t;

	// Pack a color into wire byte order; unknown codes act as GRB.
	function automatic logic [23:0] arrange(input logic [2:0] order, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		logic [23:0] w;
		case (order)
			ORD_RGB: w = {r, g, b};
			ORD_BRG: w = {b, r, g};
			ORD_RBG: w = {r, b, g};
			ORD_GBR: w = {g, b, r};
			ORD_BGR: w = {b, g, r};
			default: w = {g, r, b};
		endcase
		return w;
	endfunction

endpackage

>>> sv/lsd_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module lsd_regs import lsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output lsd_cfg_t          cfg
);

	logic [2:0]       color_order_q;
	logic [7:0]       brightness_q;
	logic [CNT_W-1:0] pixel_count_q;
	logic             wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	// Register writes on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_order_q <= RST_COLOR_ORDER;
			brightness_q  <= RST_BRIGHTNESS;
			pixel_count_q <= RST_PIXEL_COUNT;
		end else if (wr) begin
			case (paddr[ADDR_W-1:2])
				REG_COLOR_ORDER: color_order_q <= pwdata[2:0];
				REG_BRIGHTNESS:  brightness_q  <= pwdata[7:0];
				REG_PIXEL_COUNT: pixel_count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux.
	always_comb begin
		case (paddr[ADDR_W-1:2])
			REG_COLOR_ORDER: prdata = {29'd0, color_order_q};
			REG_BRIGHTNESS:  prdata = {24'd0, brightness_q};
			REG_PIXEL_COUNT: prdata = {{(32-CNT_W){1'b0}}, pixel_count_q};
			default:         prdata = 32'd0;
		endcase
	end

	assign cfg.color_order = color_order_q;
	assign cfg.brightness  = brightness_q;
	assign cfg.pixel_count = pixel_count_q;

endmodule

>>> sv/lsd_ctrl.sv
// Controller: line phase, item sequencing and result generation.
`timescale 1ns / 1ps

module lsd_ctrl import lsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic [1:0] item_kind,
	output logic       item_stall,
	input  lsd_sts_t   sts,
	output lsd_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_READY,
		ST_FILL,
		ST_LOAD_RD,
		ST_LOAD_MUL,
		ST_LOAD_SH
	} state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SEND,
		PH_LATCH
	} phase_t;

	state_t state_q, state_d;
	phase_t phase_q, phase_d;
	logic   accept;

	assign item_stall = (state_q != ST_READY) || sts.q_full;
	assign accept     = item_valid && !item_stall;

	// Next state, next phase and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_CLR;
				cmd.sweep_inc = 1'b1;
				if (sts.clr_last) begin
					cmd.sweep_clr = 1'b1;
					state_d       = ST_READY;
				end
			end
			ST_READY: begin
				if (accept) begin
					cmd.push           = 1'b1;
					cmd.res.line_level = sts.level && (phase_q == PH_SEND);
					cmd.res.status     = STS_OK;
					if (item_kind == KIND_TICK) begin
						case (phase_q)
							PH_SEND: begin
								cmd.tick_send = 1'b1;
								if (sts.bit_last && sts.word_last) begin
									if (sts.pixel_last) begin
										phase_d     = PH_LATCH;
										cmd.gap_clr = 1'b1;
									end else begin
										state_d = ST_LOAD_RD;
									end
								end
							end
							PH_LATCH: begin
								if (sts.gap_last) begin
									phase_d     = PH_IDLE;
									cmd.gap_clr = 1'b1;
								end else begin
									cmd.gap_inc = 1'b1;
								end
							end
							default: ;
						endcase
					end else if (phase_q != PH_IDLE) begin
						cmd.res.status = STS_BUSY;
					end else begin
						case (item_kind)
							KIND_SET: begin
								if (sts.idx_oor) begin
									cmd.res.status = STS_RANGE;
								end else begin
									cmd.wr_en  = 1'b1;
									cmd.wr_sel = WR_SET;
								end
							end
							KIND_FILL: begin
								if (!sts.cnt_zero) begin
									cmd.fill_load = 1'b1;
									cmd.sweep_clr = 1'b1;
									state_d       = ST_FILL;
								end
							end
							default: begin
								cmd.frame_start = 1'b1;
								if (sts.cnt_zero) begin
									phase_d     = PH_LATCH;
									cmd.gap_clr = 1'b1;
								end else begin
									phase_d = PH_SEND;
									state_d = ST_LOAD_RD;
								end
							end
						endcase
					end
					cmd.res.busy_res = (phase_d != PH_IDLE);
				end
			end
			ST_FILL: begin
				cmd.wr_en     = 1'b1;
				cmd.wr_sel    = WR_FILL;
				cmd.sweep_inc = 1'b1;
				if (sts.fill_last) begin
					cmd.sweep_clr = 1'b1;
					state_d       = ST_READY;
				end
			end
			ST_LOAD_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LOAD_MUL;
			end
			ST_LOAD_MUL: begin
				state_d = ST_LOAD_SH;
			end
			ST_LOAD_SH: begin
				cmd.shift_load = 1'b1;
				state_d        = ST_READY;
			end
			default: begin
				state_d = ST_READY;
			end
		endcase
	end

	// State and phase registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

>>> sv/lsd_dp.sv
// Datapath: pixel store, brightness scaling, bit timing counters and result queue.
`timescale 1ns / 1ps

module lsd_dp import lsd_pkg::*; #(
	parameter int MAX_PIXELS      = 1024,
	parameter int ZERO_HIGH_TICKS = 3,
	parameter int ONE_HIGH_TICKS  = 9,
	parameter int BIT_TICKS       = 12,
	parameter int LATCH_TICKS     = 500
) (
	input  logic      clk,
	input  logic      arst_n,
	input  lsd_cfg_t  cfg,
	input  lsd_item_t item,
	input  lsd_cmd_t  cmd,
	output lsd_sts_t  sts,
	output logic      res_valid,
	input  logic      res_stall,
	output lsd_res_t  res
);

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int TW = $clog2(BIT_TICKS);
	localparam int GW = (LATCH_TICKS > 1) ? $clog2(LATCH_TICKS) : 1;

	logic [23:0]      mem [MAX_PIXELS];
	logic [23:0]      rdata_q;
	logic [15:0]      prod_s1 [3];
	logic [23:0]      shift_q;
	logic [23:0]      fill_q;
	logic [AW-1:0]    sweep_q;
	logic [AW-1:0]    send_pix_q;
	logic [4:0]       send_bit_q;
	logic [TW-1:0]    bit_tick_q;
	logic [GW-1:0]    gap_q;
	lsd_res_t         q_q [2];
	logic [1:0]       qcnt_q;
	logic [CNT_W-1:0] cnt_use;
	logic [AW-1:0]    wr_addr;
	logic [23:0]      wr_data;
	logic             pop;

	// Divide a 16-bit product by 255 exactly, truncating.
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] s;
		s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
		return s[15:8];
	endfunction

	// Pixel count in use, capped at the store depth.
	assign cnt_use = (32'(cfg.pixel_count) > MAX_PIXELS) ? CNT_W'(MAX_PIXELS)
		: cfg.pixel_count;

	// Status toward the controller.
	assign sts.cnt_zero   = (cnt_use == '0);
	assign sts.idx_oor    = 32'(item.pixel_index) >= 32'(cnt_use);
	assign sts.pixel_last = (32'(send_pix_q) + 32'd1) >= 32'(cnt_use);
	assign sts.fill_last  = (32'(sweep_q) + 32'd1) >= 32'(cnt_use);
	assign sts.clr_last   = (32'(sweep_q) == MAX_PIXELS - 1);
	assign sts.bit_last   = (bit_tick_q == TW'(BIT_TICKS - 1));
	assign sts.word_last  = (32'(send_bit_q) == WORD_BITS - 1);
	assign sts.gap_last   = (gap_q == GW'(LATCH_TICKS - 1));
	assign sts.level      = shift_q[23] ? (32'(bit_tick_q) < ONE_HIGH_TICKS)
		: (32'(bit_tick_q) < ZERO_HIGH_TICKS);
	assign sts.q_full     = (qcnt_q == 2'd2);

	// Write port selection.
	always_comb begin
		case (cmd.wr_sel)
			WR_SET: begin
				wr_addr = AW'(item.pixel_index);
				wr_data = arrange(cfg.color_order, item.red, item.green, item.blue);
			end
			WR_FILL: begin
				wr_addr = sweep_q;
				wr_data = fill_q;
			end
			default: begin
				wr_addr = sweep_q;
				wr_data = 24'd0;
			end
		endcase
	end

	// Pixel store with a registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[send_pix_q];
		end
	end

	// Brightness products, then exact scaling into the shift register.
	always_ff @(posedge clk) begin
		prod_s1[0] <= rdata_q[23:16] * cfg.brightness;
		prod_s1[1] <= rdata_q[15:8] * cfg.brightness;
		prod_s1[2] <= rdata_q[7:0] * cfg.brightness;
		if (cmd.fill_load) begin
			fill_q <= arrange(cfg.color_order, item.red, item.green, item.blue);
		end
		if (cmd.shift_load) begin
			shift_q <= {div255(prod_s1[0]), div255(prod_s1[1]), div255(prod_s1[2])};
		end else if (cmd.tick_send && sts.bit_last) begin
			shift_q <= {shift_q[22:0], 1'b0};
		end
	end

	// Sweep counter shared by the clearing pass and fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (cmd.sweep_clr) begin
			sweep_q <= '0;
		end else if (cmd.sweep_inc) begin
			sweep_q <= sweep_q + AW'(1);
		end
	end

	// Bit timing, bit and pixel counters, latch gap counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_pix_q <= '0;
			send_bit_q <= '0;
			bit_tick_q <= '0;
			gap_q      <= '0;
		end else begin
			if (cmd.frame_start) begin
				send_pix_q <= '0;
				send_bit_q <= '0;
				bit_tick_q <= '0;
			end else if (cmd.tick_send) begin
				if (sts.bit_last) begin
					bit_tick_q <= '0;
					if (sts.word_last) begin
						send_bit_q <= '0;
						send_pix_q <= send_pix_q + AW'(1);
					end else begin
						send_bit_q <= send_bit_q + 5'd1;
					end
				end else begin
					bit_tick_q <= bit_tick_q + TW'(1);
				end
			end
			if (cmd.gap_clr) begin
				gap_q <= '0;
			end else if (cmd.gap_inc) begin
				gap_q <= gap_q + GW'(1);
			end
		end
	end

	// Two-entry result queue so a new beat can enter while one waits.
	assign res_valid = (qcnt_q != 2'd0);
	assign res       = q_q[0];
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= 2'd0;
		end else begin
			qcnt_q <= qcnt_q + {1'b0, cmd.push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (cmd.push && qcnt_q == 2'd1) begin
				q_q[0] <= cmd.res;
			end else begin
				q_q[0] <= q_q[1];
				if (cmd.push) begin
					q_q[1] <= cmd.res;
				end
			end
		end else if (cmd.push) begin
			if (qcnt_q == 2'd0) begin
				q_q[0] <= cmd.res;
			end else begin
				q_q[1] <= cmd.res;
			end
		end
	end

endmodule

>>> sv/addressable_led_strip_driver.sv
// Top level of the addressable LED strip driver.
`timescale 1ns / 1ps

// Drives a one-wire addressable LED strip from a pixel store of MAX_PIXELS 24-bit
// words kept in wire byte order. Each beat on the item channel gives one result beat.
// Ticks stream at one per cycle while the result queue has room and no pixel is
// being loaded. A start frame with pixels in use, and a tick that finishes the last
// bit of a pixel with more pixels to go, hold off the item channel while the next
// pixel is read from the store, multiplied by brightness, then scaled into the shift
// register. A start frame with no pixels in use goes straight to the latch gap. A
// fill writes one store entry a cycle, one per pixel in use. After reset all
// MAX_PIXELS store entries are cleared, during which no item is taken; register
// writes are taken at any time. Results are held in a two-entry queue.
module addressable_led_strip_driver import lsd_pkg::*; #(
	parameter int MAX_PIXELS      = 1024,
	parameter int ZERO_HIGH_TICKS = 3,
	parameter int ONE_HIGH_TICKS  = 9,
	parameter int BIT_TICKS       = 12,
	parameter int LATCH_TICKS     = 500
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lsd_item_t         item,
	output logic              res_valid,
	input  logic              res_stall,
	output lsd_res_t          res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	lsd_cfg_t cfg;
	lsd_cmd_t cmd;
	lsd_sts_t sts;

	lsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lsd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (item.kind),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	lsd_dp #(
		.MAX_PIXELS      (MAX_PIXELS),
		.ZERO_HIGH_TICKS (ZERO_HIGH_TICKS),
		.ONE_HIGH_TICKS  (ONE_HIGH_TICKS),
		.BIT_TICKS       (BIT_TICKS),
		.LATCH_TICKS     (LATCH_TICKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// An accepted item always leaves a result waiting on the next cycle.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> res_valid)
		else $error("accepted item produced no result beat");

	// A full result queue must hold off the item channel.
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		sts.q_full |-> item_stall)
		else $error("item channel open while result queue is full");

	// The shift register is loaded only after a store read, once the read data and the products are registered.
	a_load_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_load |-> $past(cmd.rd_en, 2))
		else $error("shift load without a matching store read");

	// The store is never written and read for a frame in the same cycle.
	a_port_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.wr_en && cmd.rd_en))
		else $error("store write and read issued together");

endmodule
